// ----- rtl/euclidean_distance_2d_core_assert.svh -----
// Assertion macros for the euclidean distance core.
// Included by modules that check their own pipeline; no other dependencies.
`ifndef EUCLIDEAN_DISTANCE_2D_CORE_ASSERT_SVH
`define EUCLIDEAN_DISTANCE_2D_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define ED2D_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define ED2D_ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define ED2D_ASSERT_IMP(lbl, clk, rst_n, a, c, msg)
`define ED2D_ASSERT_NXT(lbl, clk, rst_n, a, c, msg)
`endif
`endif

// ----- rtl/ed2d_pkg.sv -----
// Shared widths and pipeline word types for the euclidean distance core.
// No dependencies.
package ed2d_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int MAG_W   = COORD_W;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int ROOT_W  = 17;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [ROOT_W-1:0]         root_t;

    typedef struct packed {
        logic               valid;
        logic               last;
        logic [RAD_W-1:0]   rad;
        logic [REM_W-1:0]   rem;
        root_t              root;
    } cell_data_t;

endpackage

// ----- rtl/ed2d_in_if.sv -----
// Input channel: two points and the last-element flag per word.
// Depends on ed2d_pkg.
interface ed2d_in_if;
    import ed2d_pkg::*;

    logic   valid;
    logic   ready;
    coord_t x_start;
    coord_t x_end;
    coord_t y_start;
    coord_t y_end;
    logic   last_element;

    modport source (output valid, x_start, x_end, y_start, y_end, last_element, input ready);
    modport sink   (input valid, x_start, x_end, y_start, y_end, last_element, output ready);
endinterface

// ----- rtl/ed2d_out_if.sv -----
// Output channel: distance and the passed-through last flag per word.
// Depends on ed2d_pkg.
interface ed2d_out_if;
    import ed2d_pkg::*;

    logic  valid;
    logic  ready;
    root_t distance;
    logic  last_out;

    modport source (output valid, distance, last_out, input ready);
    modport sink   (input valid, distance, last_out, output ready);
endinterface

// ----- rtl/ed2d_front.sv -----
// Front end: absolute differences, squares and their sum over three stages.
// Depends on ed2d_pkg; feeds the first root cell.
module ed2d_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  ed2d_pkg::coord_t    x_start,
    input  ed2d_pkg::coord_t    x_end,
    input  ed2d_pkg::coord_t    y_start,
    input  ed2d_pkg::coord_t    y_end,
    input  logic                last_element,
    output ed2d_pkg::cell_data_t head
);
    import ed2d_pkg::*;

    logic [DIFF_W-1:0] dx;
    logic [DIFF_W-1:0] dy;
    logic [DIFF_W-1:0] dx_neg;
    logic [DIFF_W-1:0] dy_neg;
    logic [MAG_W-1:0]  adx_next;
    logic [MAG_W-1:0]  ady_next;

    logic [2:0]        valid_reg;
    logic [2:0]        last_reg;
    logic [MAG_W-1:0]  adx_reg;
    logic [MAG_W-1:0]  ady_reg;
    logic [SQ_W-1:0]   sqx_reg;
    logic [SQ_W-1:0]   sqy_reg;
    logic [SUM_W-1:0]  sum_reg;

    assign dx     = {x_end[COORD_W-1], x_end} - {x_start[COORD_W-1], x_start};
    assign dy     = {y_end[COORD_W-1], y_end} - {y_start[COORD_W-1], y_start};
    assign dx_neg = -dx;
    assign dy_neg = -dy;
    assign adx_next = dx[DIFF_W-1] ? dx_neg[MAG_W-1:0] : dx[MAG_W-1:0];
    assign ady_next = dy[DIFF_W-1] ? dy_neg[MAG_W-1:0] : dy[MAG_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg <= {last_reg[1:0], last_element};
            adx_reg  <= adx_next;
            ady_reg  <= ady_next;
            sqx_reg  <= adx_reg * adx_reg;
            sqy_reg  <= ady_reg * ady_reg;
            sum_reg  <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
        end
    end

    assign head.valid = valid_reg[2];
    assign head.last  = last_reg[2];
    assign head.rad   = {{(RAD_W-SUM_W){1'b0}}, sum_reg};
    assign head.rem   = '0;
    assign head.root  = '0;
endmodule

// ----- rtl/ed2d_sqrt_cell.sv -----
// One root digit: shift in two radicand bits, try the next root bit, restore.
// Depends on ed2d_pkg; chained by the top level.
module ed2d_sqrt_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  ed2d_pkg::cell_data_t prev,
    output ed2d_pkg::cell_data_t nxt
);
    import ed2d_pkg::*;

    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             take;
    logic             valid_reg;
    cell_data_t       data_reg;
    cell_data_t       data_next;

    assign rem_sh = {prev.rem, prev.rad[RAD_W-1 -: 2]};
    assign trial  = {2'b00, prev.root, 2'b01};
    assign diff   = rem_sh - trial;
    assign take   = rem_sh >= trial;

    always_comb
    begin
        data_next       = prev;
        data_next.rad   = {prev.rad[RAD_W-3:0], 2'b00};
        data_next.rem   = take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        data_next.root  = {prev.root[ROOT_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= prev.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        nxt       = data_reg;
        nxt.valid = valid_reg;
    end
endmodule

// ----- rtl/euclidean_distance_2d_core.sv -----
// Euclidean distance core: one word per cycle, passing through three front-end
// stages and then one root cell per result bit, 17 cells. The
// whole pipeline freezes while a result waits at the output and is not taken.
// Depends on ed2d_pkg, ed2d_in_if, ed2d_out_if, ed2d_front, ed2d_sqrt_cell.
module euclidean_distance_2d_core (
    input  logic clk,
    input  logic rst_n,
    ed2d_in_if.sink    pts,
    ed2d_out_if.source res
);
    import ed2d_pkg::*;
`include "euclidean_distance_2d_core_assert.svh"

    logic       en;
    cell_data_t chain [0:ROOT_W];

    assign en        = !chain[ROOT_W].valid || res.ready;
    assign pts.ready = en;

    ed2d_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (pts.valid),
        .x_start      (pts.x_start),
        .x_end        (pts.x_end),
        .y_start      (pts.y_start),
        .y_end        (pts.y_end),
        .last_element (pts.last_element),
        .head         (chain[0])
    );

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_cell
        ed2d_sqrt_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .prev  (chain[i]),
            .nxt   (chain[i+1])
        );
    end

    assign res.valid    = chain[ROOT_W].valid;
    assign res.distance = chain[ROOT_W].root;
    assign res.last_out = chain[ROOT_W].last;

    `ED2D_ASSERT_IMP(a_stall_blocks_input, clk, rst_n, res.valid && !res.ready, !pts.ready, "input taken while output stalled")
    `ED2D_ASSERT_NXT(a_accept_enters, clk, rst_n, pts.valid && pts.ready, u_front.valid_reg[0], "accepted word did not reach front end")
    `ED2D_ASSERT_NXT(a_stall_holds_root, clk, rst_n, res.valid && !res.ready, $stable(res.distance) && res.valid, "stalled result changed")
    `ED2D_ASSERT_IMP(a_rem_bound, clk, rst_n, res.valid, {1'b0, chain[ROOT_W].rem} <= {1'b0, chain[ROOT_W].root, 1'b0}, "root remainder out of range")
endmodule
